[rtl/utf8_dec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// Result types, byte class limits and value limits shared by the UTF-8
// stream decoder files.
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

    typedef struct packed {
        logic [20:0] code_point;
        logic        valid_res;
        logic [2:0]  byte_count;
        logic        last_of_run;
        logic        string_done;
    } res_t;

    // Up to two results come out of one byte
    typedef struct packed {
        logic [1:0] num;
        res_t       res0;
        res_t       res1;
    } dec_t;

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [7:0]  LEAD_MAX    = 8'hF4;
    localparam logic [7:0]  CONT_MAX    = 8'hBF;

    localparam logic [20:0] MIN_CP2     = 21'h00080;
    localparam logic [20:0] MIN_CP3     = 21'h00800;
    localparam logic [20:0] SURR_LO     = 21'h0D800;
    localparam logic [20:0] SURR_HI     = 21'h0DFFF;
    localparam logic [20:0] MIN_CP4     = 21'h10000;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;

    // Full length of a sequence given its lead byte
    function automatic logic [2:0] seq_total(input logic [7:0] lead);
        logic [2:0] t;
        if (lead < LEAD3_MIN)
            t = 3'd2;
        else if (lead < LEAD4_MIN)
            t = 3'd3;
        else
            t = 3'd4;
        return t;
    endfunction

    function automatic res_t make_res(input logic [20:0] cp, input logic ok,
                                      input logic [2:0] cnt);
        res_t r;
        r.code_point  = ok ? cp : 21'd0;
        r.valid_res   = ok;
        r.byte_count  = cnt;
        r.last_of_run = 1'b0;
        r.string_done = 1'b0;
        return r;
    endfunction

endpackage

[rtl/utf8_dec_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_ifs
// Valid/ready channels of the UTF-8 stream decoder: raw bytes in,
// decoded characters out.
// ----------------------------------------------------------------------------
interface utf8_dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       is_last_byte;

    modport source (output valid, output byte_in, output is_last_byte, input ready);
    modport sink   (input valid, input byte_in, input is_last_byte, output ready);
endinterface

interface utf8_dec_char_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        valid_res;
    logic [2:0]  byte_count;
    logic        last_of_run;
    logic        string_done;

    modport source (output valid, output code_point, output valid_res,
                    output byte_count, output last_of_run, output string_done,
                    input ready);
    modport sink   (input valid, input code_point, input valid_res,
                    input byte_count, input last_of_run, input string_done,
                    output ready);
endinterface

[rtl/utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream decoder and validator with a result queue.
// ----------------------------------------------------------------------------
// Accepts one byte beat per cycle and emits one character beat per result:
// code point, valid flag, bytes consumed, and end-of-run / end-of-string
// marks. A byte is registered, decoded in the next cycle against the open
// sequence state, and its zero, one or two results land in a DEPTH-entry
// queue, so the first result reaches the output port once it has passed
// the input register and the queue write, and is read from the queue.
// Throughput is one byte per cycle while each byte yields at most one
// result; a byte that yields two results takes two beats of the output
// port, which moves one result per cycle. The byte channel holds ready low
// only when the queue lacks room for two results from each byte in flight.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit
    import utf8_dec_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    utf8_dec_byte_if.sink          bytes,
    utf8_dec_char_if.source        chars
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    dec_t          dec;

    res_t          fifo_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fifo_count_reg, fifo_count_next;
    logic [CW:0]   load;
    logic          accept;
    logic          pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Reserve two slots for each byte that may still write the queue
    assign load        = (CW+1)'(fifo_count_reg) + (in_valid_reg ? (CW+1)'(2) : '0);
    assign bytes.ready = load <= (CW+1)'(DEPTH - 2);
    assign accept      = bytes.valid && bytes.ready;
    assign pop         = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= bytes.byte_in;
            in_last_reg <= bytes.is_last_byte;
        end
    end

    utf8_dec_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_valid_reg),
        .byte_in      (in_byte_reg),
        .is_last_byte (in_last_reg),
        .dec          (dec)
    );

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (in_valid_reg)
        begin
            unique case (dec.num)
                2'd1:    wr_ptr_next = wr_ptr_plus1;
                2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
                default: wr_ptr_next = wr_ptr_reg;
            endcase
        end
        rd_ptr_next     = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fifo_count_next = fifo_count_reg
                          + (in_valid_reg ? CW'(dec.num) : '0)
                          - (pop ? CW'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && dec.num != 2'd0)
            fifo_mem[wr_ptr_reg] <= dec.res0;
        if (in_valid_reg && dec.num == 2'd2)
            fifo_mem[wr_ptr_plus1] <= dec.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    assign chars.valid       = fifo_count_reg != '0;
    assign chars.code_point  = fifo_mem[rd_ptr_reg].code_point;
    assign chars.valid_res   = fifo_mem[rd_ptr_reg].valid_res;
    assign chars.byte_count  = fifo_mem[rd_ptr_reg].byte_count;
    assign chars.last_of_run = fifo_mem[rd_ptr_reg].last_of_run;
    assign chars.string_done = fifo_mem[rd_ptr_reg].string_done;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> ((CW+1)'(fifo_count_reg) + (CW+1)'(dec.num) <= (CW+1)'(DEPTH)))
        else $error("result queue overflow");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg) |-> (dec.num != 2'd0))
        else $error("end of string produced no result");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.string_done) |-> chars.last_of_run)
        else $error("string_done without last_of_run");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && !pop) |=> $stable(fifo_count_reg))
        else $error("queue count moved without a write or a read");

    a_invalid_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && !chars.valid_res) |-> (chars.code_point == 21'd0))
        else $error("error result carries a code point");
`endif

endmodule

[rtl/utf8_dec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_core
// Sequence state and combinational decode of one byte into zero, one or two
// results.
// ----------------------------------------------------------------------------
module utf8_dec_core
    import utf8_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic       is_last_byte,
    output dec_t       dec
);

    logic [7:0]  lead_byte_reg,     lead_byte_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic [20:0] partial_value_reg, partial_value_next;
    logic        bad_byte_seen_reg, bad_byte_seen_next;

    always_comb
    begin
        logic        starts;
        logic        cont;
        logic [1:0]  n;
        res_t        r0;
        res_t        r1;
        res_t        r;
        logic        ok;
        logic [2:0]  tot;

        starts = (byte_in < ASCII_LIMIT) || (byte_in >= LEAD2_MIN && byte_in <= LEAD_MAX);
        cont   = (byte_in >= ASCII_LIMIT) && (byte_in <= CONT_MAX);
        n      = 2'd0;
        r0     = '0;
        r1     = '0;
        r      = '0;
        ok     = 1'b0;
        tot    = 3'd0;

        lead_byte_next     = lead_byte_reg;
        pending_count_next = pending_count_reg;
        partial_value_next = partial_value_reg;
        bad_byte_seen_next = bad_byte_seen_reg;

        // A new character start cuts the open sequence short
        if (pending_count_reg != 2'd0 && starts)
        begin
            r = make_res(21'd0, 1'b0,
                         seq_total(lead_byte_reg) - {1'b0, pending_count_reg});
            if (n == 2'd0) r0 = r; else r1 = r;
            n = n + 2'd1;
        end

        if (pending_count_reg == 2'd0 || starts)
        begin
            lead_byte_next     = 8'd0;
            pending_count_next = 2'd0;
            partial_value_next = 21'd0;
            bad_byte_seen_next = 1'b0;
            if (byte_in < ASCII_LIMIT)
            begin
                r = make_res({13'd0, byte_in}, 1'b1, 3'd1);
                if (n == 2'd0) r0 = r; else r1 = r;
                n = n + 2'd1;
            end
            else if (byte_in < LEAD2_MIN || byte_in > LEAD_MAX)
            begin
                r = make_res(21'd0, 1'b0, 3'd1);
                if (n == 2'd0) r0 = r; else r1 = r;
                n = n + 2'd1;
            end
            else
            begin
                lead_byte_next = byte_in;
                if (byte_in < LEAD3_MIN)
                begin
                    pending_count_next = 2'd1;
                    partial_value_next = {16'd0, byte_in[4:0]};
                end
                else if (byte_in < LEAD4_MIN)
                begin
                    pending_count_next = 2'd2;
                    partial_value_next = {17'd0, byte_in[3:0]};
                end
                else
                begin
                    pending_count_next = 2'd3;
                    partial_value_next = {18'd0, byte_in[2:0]};
                end
            end
        end
        else
        begin
            // Continuation, or a stray byte swallowed into the error
            partial_value_next = {partial_value_reg[14:0], byte_in[5:0]};
            bad_byte_seen_next = bad_byte_seen_reg | ~cont;
            pending_count_next = pending_count_reg - 2'd1;
            if (pending_count_next == 2'd0)
            begin
                tot = seq_total(lead_byte_reg);
                ok  = 1'b0;
                if (!bad_byte_seen_next)
                begin
                    unique case (tot)
                        3'd2:    ok = partial_value_next >= MIN_CP2;
                        3'd3:    ok = partial_value_next >= MIN_CP3 &&
                                      !(partial_value_next >= SURR_LO &&
                                        partial_value_next <= SURR_HI);
                        default: ok = partial_value_next >= MIN_CP4 &&
                                      partial_value_next <= MAX_CP;
                    endcase
                end
                r = make_res(partial_value_next, ok, tot);
                if (n == 2'd0) r0 = r; else r1 = r;
                n = n + 2'd1;
                lead_byte_next     = 8'd0;
                partial_value_next = 21'd0;
                bad_byte_seen_next = 1'b0;
            end
        end

        // Close whatever is still open at end of string
        if (is_last_byte && pending_count_next != 2'd0)
        begin
            r = make_res(21'd0, 1'b0,
                         seq_total(lead_byte_next) - {1'b0, pending_count_next});
            if (n == 2'd0) r0 = r; else r1 = r;
            n = n + 2'd1;
            lead_byte_next     = 8'd0;
            pending_count_next = 2'd0;
            partial_value_next = 21'd0;
            bad_byte_seen_next = 1'b0;
        end

        if (n == 2'd1)
        begin
            r0.last_of_run = 1'b1;
            r0.string_done = is_last_byte;
        end
        else if (n == 2'd2)
        begin
            r1.last_of_run = 1'b1;
            r1.string_done = is_last_byte;
        end

        dec.num  = n;
        dec.res0 = r0;
        dec.res1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_byte_reg     <= 8'd0;
            pending_count_reg <= 2'd0;
            partial_value_reg <= 21'd0;
            bad_byte_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            lead_byte_reg     <= lead_byte_next;
            pending_count_reg <= pending_count_next;
            partial_value_reg <= partial_value_next;
            bad_byte_seen_reg <= bad_byte_seen_next;
        end
    end

endmodule

[bench/utf8_stream_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// Watches the byte and character channels of the UTF-8 stream decoder,
// predicts the characters that each accepted byte beat causes, and compares
// every accepted character beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker
    import utf8_dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [20:0] out_code_point,
    input  logic        out_valid_res,
    input  logic [2:0]  out_byte_count,
    input  logic        out_last_of_run,
    input  logic        out_string_done,
    output int          fail_count,
    output int          chars_due
);

    // Open sequence state of the predictor
    logic [7:0]  seq_lead  = 8'd0;
    logic [1:0]  seq_left  = 2'd0;
    logic [20:0] seq_value = 21'd0;
    logic        seq_bad   = 1'b0;

    res_t expected_chars[$];
    res_t byte_chars[$];
    int   mismatches = 0;
    int   due = 0;

    assign fail_count = mismatches;
    assign chars_due  = due;

    function automatic logic can_start(input logic [7:0] b);
        return (b < ASCII_LIMIT) || (b >= LEAD2_MIN && b <= LEAD_MAX);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= ASCII_LIMIT) && (b <= CONT_MAX);
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        if (lead >= LEAD4_MIN)
            n = 3'd4;
        else if (lead >= LEAD3_MIN)
            n = 3'd3;
        else
            n = 3'd2;
        return n;
    endfunction

    task automatic add_char(input logic [20:0] cp, input logic ok, input logic [2:0] cnt);
        res_t r;
        r.code_point  = ok ? cp : 21'd0;
        r.valid_res   = ok;
        r.byte_count  = cnt;
        r.last_of_run = 1'b0;
        r.string_done = 1'b0;
        byte_chars.push_back(r);
    endtask

    task automatic clear_seq();
        seq_lead  = 8'd0;
        seq_left  = 2'd0;
        seq_value = 21'd0;
        seq_bad   = 1'b0;
    endtask

    task automatic open_char(input logic [7:0] b);
        if (b < ASCII_LIMIT)
            add_char({13'd0, b}, 1'b1, 3'd1);
        else if (b < LEAD2_MIN || b > LEAD_MAX)
            add_char(21'd0, 1'b0, 3'd1);
        else
        begin
            seq_lead = b;
            seq_bad  = 1'b0;
            if (b < LEAD3_MIN)
            begin
                seq_left  = 2'd1;
                seq_value = {16'd0, b[4:0]};
            end
            else if (b < LEAD4_MIN)
            begin
                seq_left  = 2'd2;
                seq_value = {17'd0, b[3:0]};
            end
            else
            begin
                seq_left  = 2'd3;
                seq_value = {18'd0, b[2:0]};
            end
        end
    endtask

    task automatic close_char();
        logic [2:0] n;
        logic       ok;
        n  = seq_len(seq_lead);
        ok = !seq_bad;
        if (ok)
        begin
            if (n == 3'd2)
                ok = seq_value >= MIN_CP2;
            else if (n == 3'd3)
                ok = seq_value >= MIN_CP3 && !(seq_value >= SURR_LO && seq_value <= SURR_HI);
            else
                ok = seq_value >= MIN_CP4 && seq_value <= MAX_CP;
        end
        add_char(seq_value, ok, n);
        clear_seq();
    endtask

    // Work out the characters that one byte beat causes
    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        res_t r;
        if (seq_left != 2'd0)
        begin
            if (can_start(b))
            begin
                add_char(21'd0, 1'b0, seq_len(seq_lead) - {1'b0, seq_left});
                clear_seq();
                open_char(b);
            end
            else
            begin
                if (!is_trail(b))
                    seq_bad = 1'b1;
                seq_value = {seq_value[14:0], b[5:0]};
                seq_left  = seq_left - 2'd1;
                if (seq_left == 2'd0)
                    close_char();
            end
        end
        else
            open_char(b);

        if (is_last && seq_left != 2'd0)
        begin
            add_char(21'd0, 1'b0, seq_len(seq_lead) - {1'b0, seq_left});
            clear_seq();
        end

        if (byte_chars.size() > 0)
        begin
            r = byte_chars.pop_back();
            r.last_of_run = 1'b1;
            r.string_done = is_last;
            byte_chars.push_back(r);
        end
        while (byte_chars.size() > 0)
            expected_chars.push_back(byte_chars.pop_front());
    endtask

    task automatic check_char();
        res_t want;
        if (expected_chars.size() == 0)
        begin
            $error("unexpected character beat: code_point %0h", out_code_point);
            mismatches++;
        end
        else
        begin
            want = expected_chars.pop_front();
            if (out_code_point !== want.code_point)
            begin
                $error("code_point: expected %0h, actual %0h", want.code_point, out_code_point);
                mismatches++;
            end
            if (out_valid_res !== want.valid_res)
            begin
                $error("valid_res: expected %0d, actual %0d", want.valid_res, out_valid_res);
                mismatches++;
            end
            if (out_byte_count !== want.byte_count)
            begin
                $error("byte_count: expected %0d, actual %0d", want.byte_count, out_byte_count);
                mismatches++;
            end
            if (out_last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                       out_last_of_run);
                mismatches++;
            end
            if (out_string_done !== want.string_done)
            begin
                $error("string_done: expected %0d, actual %0d", want.string_done,
                       out_string_done);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // A character beat never comes from a byte taken at the same edge
            if (out_valid && out_ready)
                check_char();
            if (in_valid && in_ready)
                decode_byte(in_byte, in_last);
            due <= expected_chars.size();
        end
    end

endmodule

[bench/utf8_stream_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_tb
// Drives byte strings into the UTF-8 stream decoder: a directed set of edge
// cases, then random strings of mostly well-formed characters mixed with
// overlong forms, surrogates, truncations, swallowed bytes and noise, under
// three idle patterns. The checker beside the block scores every beat.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_tb
    import utf8_dec_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 385;
    localparam int DRAIN_CYCLES  = 20;

    logic clk;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int   src_idle = 0;
    int   snk_idle = 0;
    int   cycles = 0;
    int   items_sent = 0;
    int   fail_count;
    int   chars_due;

    logic [7:0] string_bytes[$];

    utf8_dec_byte_if byte_ch ();
    utf8_dec_char_if char_ch ();

    assign char_ch.ready = sink_ready;

    utf8_stream_decoder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .chars (char_ch)
    );

    utf8_stream_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (byte_ch.valid),
        .in_ready        (byte_ch.ready),
        .in_byte         (byte_ch.byte_in),
        .in_last         (byte_ch.is_last_byte),
        .out_valid       (char_ch.valid),
        .out_ready       (char_ch.ready),
        .out_code_point  (char_ch.code_point),
        .out_valid_res   (char_ch.valid_res),
        .out_byte_count  (char_ch.byte_count),
        .out_last_of_run (char_ch.last_of_run),
        .out_string_done (char_ch.string_done),
        .fail_count      (fail_count),
        .chars_due       (chars_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        sink_ready <= ($urandom_range(0, 99) >= snk_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold the beat until taken; valid drops only on an idle cycle
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_in      <= b;
        byte_ch.is_last_byte <= is_last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (chars_due != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] utf8_encode(input logic [20:0] cp, input int len);
        logic [31:0] w;
        case (len)
            1:       w = {1'b0, cp[6:0], 24'd0};
            2:       w = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
            3:       w = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
            default: w = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                          2'b10, cp[5:0]};
        endcase
        return w;
    endfunction

    function automatic logic [20:0] random_cp(input int len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                while (cp >= SURR_LO && cp <= SURR_HI)
                    cp = 21'($urandom_range('h800, 'hFFFF));
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic push_bytes(input logic [31:0] w, input int cnt);
        for (int i = 0; i < cnt; i++)
            string_bytes.push_back(w[31 - 8 * i -: 8]);
    endtask

    // Append one character, mostly well formed, to the string under construction
    task automatic append_char();
        int          pick;
        int          len;
        int          pos;
        int          bad;
        logic [20:0] cp;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(2, 4);
        if (pick < 25)
            push_bytes(utf8_encode(random_cp(1), 1), 1);
        else if (pick < 78)
        begin
            len = (pick < 45) ? 2 : (pick < 63) ? 3 : 4;
            push_bytes(utf8_encode(random_cp(len), len), len);
        end
        else if (pick < 82)
        begin
            // overlong form
            cp = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
            push_bytes(utf8_encode(cp, len), len);
        end
        else if (pick < 85)
            push_bytes(utf8_encode(21'($urandom_range(SURR_LO, SURR_HI)), 3), 3);
        else if (pick < 87)
            push_bytes(utf8_encode(21'($urandom_range('h110000, 'h1FFFFF)), 4), 4);
        else if (pick < 92)
            push_bytes(utf8_encode(random_cp(len), len), $urandom_range(1, len - 1));
        else if (pick < 96)
        begin
            // swallow a byte that can neither continue nor start a character
            w   = utf8_encode(random_cp(len), len);
            pos = $urandom_range(1, len - 1);
            bad = $urandom_range(0, 12);
            w[31 - 8 * pos -: 8] = (bad < 2) ? 8'(8'hC0 + bad) : 8'(8'hF5 + bad - 2);
            push_bytes(w, len);
        end
        else
            string_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_string();
        int nchars;
        string_bytes.delete();
        nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        repeat (nchars)
            append_char();
        for (int i = 0; i < string_bytes.size(); i++)
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
    endtask

    task automatic send_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // shortest two-byte form
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        // surrogate
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        // overlong three-byte form
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b1);
        // above the top of the code space
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        // ASCII ends an open sequence
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
        // lead inside an open sequence
        send_byte(8'hE2, 1'b0); send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
        // swallowed byte runs to full length
        send_byte(8'hF0, 1'b0); send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        // end of string while open, two errors from one byte
        send_byte(8'hE2, 1'b0); send_byte(8'hC3, 1'b1);
    endtask

    task automatic run_phase(input int sidle, input int ridle, input logic with_directed);
        int stop_at;
        src_idle = sidle;
        snk_idle = ridle;
        if (with_directed)
            send_directed();
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
            send_random_string();
        // pause the sender until every character has come out
        wait_drained();
    endtask

    initial
    begin
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_in      <= 8'd0;
        byte_ch.is_last_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_phase(18, 84, 1'b1);
        run_phase(84, 18, 1'b0);
        run_phase(0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && chars_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[utf8_stream_decoder_unit.f]
rtl/utf8_dec_pkg.sv
rtl/utf8_dec_ifs.sv
rtl/utf8_dec_core.sv
rtl/utf8_stream_decoder_unit.sv
bench/utf8_stream_decoder_checker.sv
bench/utf8_stream_decoder_unit_tb.sv
